/* src/stack_allocator_engine_top_defines.svh */
// assertion macros shared by the checker
`ifndef STACK_ALLOCATOR_ENGINE_TOP_DEFINES_SVH
`define STACK_ALLOCATOR_ENGINE_TOP_DEFINES_SVH

// checked only while out of reset
`define SAE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SAE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/sae_pkg.sv */
package sae_pkg;

  localparam int MAX_LIVE     = 64;
  localparam int HEADER_BYTES = 1;
  localparam int ADDR_W       = 32;
  localparam int DATA_W       = 32;
  localparam int CNT_W        = $clog2(MAX_LIVE + 1);
  localparam int IDX_W        = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
  localparam int ADJ_W        = 8;
  localparam int CFG_IDX_W    = 2;

  localparam logic [DATA_W-1:0] POOL_RESET = DATA_W'(65536);

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE = 2'd0,
    CFG_POOL = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [ADJ_W-1:0]  adj;
    logic [ADDR_W-1:0] addr;
  } stack_entry_t;

  // forward pad so the block is aligned with room for the header in front
  function automatic logic [ADJ_W-1:0] header_adjust(input logic [ADJ_W-1:0] top_lo,
                                                     input logic [2:0] lg);
    logic [ADJ_W-1:0] mask;
    logic [ADJ_W-1:0] a;
    logic [ADJ_W-1:0] hdr;
    logic [ADJ_W:0]   up;
    mask = (ADJ_W'(1) << lg) - ADJ_W'(1);
    hdr  = ADJ_W'(HEADER_BYTES);
    a    = (ADJ_W'(0) - top_lo) & mask;
    up   = '0;
    if (a < hdr) begin
      up = (({1'b0, hdr - a} + {1'b0, mask}) >> lg) << lg;
    end
    return a + up[ADJ_W-1:0];
  endfunction

endpackage

/* src/sae_stack.sv */
module sae_stack import sae_pkg::*; (
  input  logic         clk,
  input  logic         wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  stack_entry_t wr_entry,
  input  logic [IDX_W-1:0] rd_idx,
  output stack_entry_t rd_entry
);

  stack_entry_t mem [MAX_LIVE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_idx];
  end

endmodule

/* src/stack_allocator_engine_top.sv */
// stack allocator: LIFO bump allocation over one region, with an aligned header pad
// request channel: start with action, request_bytes, align_log2, free_address;
//   a request is taken on a clock edge with start high and busy low
// result channel: done is high for exactly one cycle with status, block_address,
//   bytes_used and live_count; the receiver cannot stall, so nothing waits
// result timing: done and the result outputs are registered at the edge that leaves S_EXEC
// pacing: a new request is taken only after the last one leaves S_EXEC; the tracking stack sits in
//   a memory with a registered read, read at the accepting edge and consumed on the next one,
//   and busy covers that cycle
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, ready while
//   not busy; writing base_address also empties the allocator
// reset: synchronous, active high; base 0, pool 65536 bytes, nothing live;
//   the stack memory is not cleared, only entries below the live count are used
module stack_allocator_engine_top import sae_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action,
  input  logic [DATA_W-1:0]    request_bytes,
  input  logic [2:0]           align_log2,
  input  logic [DATA_W-1:0]    free_address,
  output logic                 done,
  output logic [1:0]           status,
  output logic [DATA_W-1:0]    block_address,
  output logic [DATA_W-1:0]    bytes_used,
  output logic [CNT_W-1:0]     live_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state;
  logic [DATA_W-1:0]  base_address;
  logic [DATA_W-1:0]  pool_bytes;
  logic [ADDR_W-1:0]  top_address;
  logic [DATA_W-1:0]  used_total;
  logic [CNT_W-1:0]   alloc_count;

  logic [1:0]         act_q;
  logic [DATA_W-1:0]  req_q;
  logic [2:0]         align_q;
  logic [DATA_W-1:0]  faddr_q;

  logic [ADDR_W-1:0]  top_next;
  logic [DATA_W-1:0]  used_next;
  logic [CNT_W-1:0]   count_next;
  logic [1:0]         status_next;
  logic [DATA_W-1:0]  block_next;

  logic [ADJ_W-1:0]   adj;
  logic [DATA_W+1:0]  need_total;
  logic [ADDR_W-1:0]  new_addr;
  logic [ADDR_W-1:0]  span;
  logic [CNT_W-1:0]   count_dec;
  logic               wr_en;
  stack_entry_t       wr_entry;
  stack_entry_t       rd_entry;

  assign busy      = (state == S_EXEC);
  assign cfg_ready = !busy;
  assign count_dec = alloc_count - CNT_W'(1);

  assign adj        = header_adjust(top_address[ADJ_W-1:0], align_q);
  assign need_total = (DATA_W+2)'(used_total) + (DATA_W+2)'(req_q) + (DATA_W+2)'(adj);
  assign new_addr   = top_address + ADDR_W'(adj);
  assign span       = (top_address - rd_entry.addr) + ADDR_W'(rd_entry.adj);
  assign wr_entry   = '{adj: adj, addr: new_addr};

  always_comb begin
    top_next    = top_address;
    used_next   = used_total;
    count_next  = alloc_count;
    status_next = ST_OK;
    block_next  = '0;
    wr_en       = 1'b0;
    case (act_q)
      ACT_ALLOC: begin
        if (alloc_count >= CNT_W'(MAX_LIVE)) begin
          status_next = ST_FULL;
        end else if (need_total > (DATA_W+2)'(pool_bytes)) begin
          status_next = ST_NO_SPACE;
        end else begin
          wr_en      = busy;
          top_next   = new_addr + ADDR_W'(req_q);
          used_next  = DATA_W'(need_total);
          count_next = alloc_count + CNT_W'(1);
          block_next = DATA_W'(new_addr);
        end
      end
      ACT_FREE: begin
        if (alloc_count == '0 || DATA_W'(rd_entry.addr) != faddr_q) begin
          status_next = ST_BAD_FREE;
        end else begin
          used_next  = used_total - DATA_W'(span);
          top_next   = rd_entry.addr - ADDR_W'(rd_entry.adj);
          count_next = count_dec;
        end
      end
      ACT_CLEAR: begin
        top_next   = ADDR_W'(base_address);
        used_next  = '0;
        count_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  sae_stack u_stack (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_idx   (alloc_count[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_idx   (count_dec[IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      base_address <= '0;
      pool_bytes   <= POOL_RESET;
      top_address  <= '0;
      used_total   <= '0;
      alloc_count  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            act_q   <= action;
            req_q   <= request_bytes;
            align_q <= align_log2;
            faddr_q <= free_address;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          top_address   <= top_next;
          used_total    <= used_next;
          alloc_count   <= count_next;
          status        <= status_next;
          block_address <= block_next;
          bytes_used    <= used_next;
          live_count    <= count_next;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE: begin
            base_address <= cfg_data;
            top_address  <= ADDR_W'(cfg_data);
            used_total   <= '0;
            alloc_count  <= '0;
          end
          CFG_POOL: begin
            pool_bytes <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* src/sae_checker.sv */
`include "stack_allocator_engine_top_defines.svh"

module sae_checker import sae_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [1:0]           status,
  input logic [DATA_W-1:0]    block_address,
  input logic [CNT_W-1:0]     live_count,
  input logic                 cfg_ready
);

  // an accepted request holds off the next one and is answered with done
  `SAE_ASSERT(a_accept_busy, start && !busy |=> busy, "request accepted without busy")
  `SAE_ASSERT(a_accept_done, start && !busy |-> ##2 done, "no result for accepted request")
  // failed requests never hand out an address
  `SAE_ASSERT(a_fail_zero, done && status != ST_OK |-> block_address == '0,
              "address returned on failure")
  // a successful allocation leaves at least one live block
  `SAE_ASSERT(a_alloc_live, done && status == ST_OK && block_address != '0 |->
              live_count != '0, "allocation without live block")
  `SAE_ASSERT_ALWAYS(a_cfg_idle, cfg_ready |-> !busy, "config ready while busy")

endmodule

bind stack_allocator_engine_top sae_checker u_sae_checker (.*);

/* tb/tb_stack_allocator_engine_top.sv */
`timescale 1ns / 100ps

module tb_stack_allocator_engine_top;
  import sae_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int IDLE_LIMIT = 1000;

  typedef struct {
    status_t          st;
    logic [31:0]      blk;
    logic [31:0]      used;
    logic [CNT_W-1:0] cnt;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [31:0]   base_addr;
    logic [31:0]   pool_size;
    logic [31:0]   top;
    logic [31:0]   used;
    int unsigned   live;
    logic [7:0]    pad_stack [MAX_LIVE];
    logic [31:0]   block_stack [MAX_LIVE];
    alloc_result_t expected_results [$];
    int            errors;

    function new();
      base_addr = '0;
      pool_size = 32'd65536;
      errors = 0;
      empty_pool();
    endfunction

    function void empty_pool();
      top = base_addr;
      used = '0;
      live = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] val);
      if (idx == CFG_BASE) begin
        base_addr = val;
        empty_pool();
      end else if (idx == CFG_POOL) begin
        pool_size = val;
      end
    endfunction

    // forward pad from top so the block is aligned with room for the header
    function logic [63:0] header_pad(logic [31:0] addr, logic [63:0] align);
      logic [63:0] a;
      logic [63:0] need;
      a = (align - ({32'b0, addr} & (align - 64'd1))) & (align - 64'd1);
      if (a < 64'(HEADER_BYTES)) begin
        need = 64'(HEADER_BYTES) - a;
        a = a + align * ((need + align - 64'd1) / align);
      end
      return a;
    endfunction

    function logic [31:0] latest_block();
      return (live > 0) ? block_stack[live-1] : 32'h0;
    endfunction

    function void take_request(logic [1:0] act, logic [31:0] req, logic [2:0] lg,
                               logic [31:0] fa);
      alloc_result_t r;
      logic [63:0]   align;
      logic [63:0]   pad;
      logic [31:0]   addr;
      logic [31:0]   span;
      int unsigned   k;
      r.st = ST_OK;
      r.blk = '0;
      align = 64'd1 << lg;
      case (act)
        ACT_ALLOC: begin
          if (live >= MAX_LIVE) begin
            r.st = ST_FULL;
          end else begin
            pad = header_pad(top, align);
            if (pad + {32'b0, req} + {32'b0, used} > {32'b0, pool_size}) begin
              r.st = ST_NO_SPACE;
            end else begin
              addr = top + pad[31:0];
              pad_stack[live] = pad[7:0];
              block_stack[live] = addr;
              live++;
              top = addr + req;
              used = used + req + pad[31:0];
              r.blk = addr;
            end
          end
        end
        ACT_FREE: begin
          if (live == 0 || block_stack[live-1] != fa) begin
            r.st = ST_BAD_FREE;
          end else begin
            k = live - 1;
            span = (top - block_stack[k]) + {24'b0, pad_stack[k]};
            used = used - span;
            top = block_stack[k] - {24'b0, pad_stack[k]};
            live = k;
          end
        end
        ACT_CLEAR: empty_pool();
        default: ;
      endcase
      r.used = used;
      r.cnt = CNT_W'(live);
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task match_result(logic [1:0] st, logic [31:0] blk, logic [31:0] u,
                      logic [CNT_W-1:0] cnt);
      alloc_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing expected, status %0d", st));
        return;
      end
      want = expected_results.pop_front();
      if (st != want.st)
        report($sformatf("status got %0d expected %0d", st, want.st));
      if (blk != want.blk)
        report($sformatf("block_address got %h expected %h", blk, want.blk));
      if (u != want.used)
        report($sformatf("bytes_used got %h expected %h", u, want.used));
      if (cnt != want.cnt)
        report($sformatf("live_count got %0d expected %0d", cnt, want.cnt));
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           action;
  logic [DATA_W-1:0]    request_bytes;
  logic [2:0]           align_log2;
  logic [DATA_W-1:0]    free_address;
  logic                 done;
  logic [1:0]           status;
  logic [DATA_W-1:0]    block_address;
  logic [DATA_W-1:0]    bytes_used;
  logic [CNT_W-1:0]     live_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  alloc_scoreboard sb;
  bit              no_idle;
  int              idle_cycles;

  stack_allocator_engine_top uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .request_bytes (request_bytes),
    .align_log2    (align_log2),
    .free_address  (free_address),
    .done          (done),
    .status        (status),
    .block_address (block_address),
    .bytes_used    (bytes_used),
    .live_count    (live_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.match_result(status, block_address, bytes_used, live_count);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic [1:0] act, logic [31:0] req, logic [2:0] lg,
                              logic [31:0] fa);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    request_bytes <= req;
    align_log2 <= lg;
    free_address <= fa;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.take_request(act, req, lg, fa);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_size();
    logic [31:0] room;
    room = sb.pool_size - sb.used;
    case ($urandom_range(0, 9))
      6:       return $urandom_range(0, 4096);
      7:       return $urandom;
      8:       return room - $urandom_range(0, 140);
      9:       return '0;
      default: return $urandom_range(0, 48);
    endcase
  endfunction

  task automatic random_item();
    int          pick;
    logic [31:0] fa;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      send_request(ACT_ALLOC, pick_size(), 3'($urandom_range(0, 7)), $urandom);
    end else if (pick < 90) begin
      if (sb.live > 0 && $urandom_range(0, 7) != 0) fa = sb.latest_block();
      else if ($urandom_range(0, 1) == 0) fa = sb.latest_block() ^ (32'd1 << $urandom_range(0, 31));
      else fa = $urandom;
      send_request(ACT_FREE, $urandom, 3'($urandom_range(0, 7)), fa);
    end else if (pick < 93) begin
      send_request(ACT_CLEAR, $urandom, 3'($urandom_range(0, 7)), $urandom);
    end else if (pick < 96) begin
      send_request(ACT_NONE, $urandom, 3'($urandom_range(0, 7)), $urandom);
    end else begin
      send_request(2'($urandom_range(0, 3)), $urandom, 3'($urandom_range(0, 7)), $urandom);
    end
  endtask

  // push small blocks, two more than the free stack entries, aiming to overflow the tracking stack
  task automatic fill_stack();
    int n;
    n = MAX_LIVE + 2 - int'(sb.live);
    repeat (n) send_request(ACT_ALLOC, $urandom_range(0, 1), 3'd0, $urandom);
  endtask

  task automatic run_phase(logic [31:0] base, logic [31:0] pool, int n);
    write_reg(CFG_POOL, pool);
    write_reg(CFG_BASE, base);
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == 60) fill_stack();
      if (i % 200 == 199) wait_idle();
      random_item();
    end
    wait_idle();
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    action <= ACT_ALLOC;
    request_bytes <= '0;
    align_log2 <= '0;
    free_address <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BASE;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_POOL, 32'd65536);
    write_reg(CFG_BASE, 32'd0);
    send_request(ACT_ALLOC, 32'd0, 3'd0, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC, 32'd100, 3'd7, 32'd0);
    send_request(ACT_FREE, 32'd0, 3'd0, 32'd0);
    send_request(ACT_FREE, 32'hFFFF_FFFF, 3'd7, sb.latest_block());
    send_request(ACT_FREE, 32'd0, 3'd0, sb.latest_block());
    send_request(ACT_FREE, 32'd0, 3'd0, 32'd0);
    send_request(ACT_NONE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC, 32'hFFFF_FFFF, 3'd7, 32'd0);
    send_request(ACT_ALLOC, 32'd65535, 3'd0, 32'd0);
    send_request(ACT_ALLOC, 32'd0, 3'd0, 32'd0);
    send_request(ACT_CLEAR, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    for (int lg = 0; lg < 8; lg++) send_request(ACT_ALLOC, 32'd3, 3'(lg), 32'd0);
    send_request(ACT_FREE, 32'd0, 3'd0, sb.latest_block());
    send_request(ACT_FREE, 32'd0, 3'd0, sb.latest_block() ^ 32'h8000_0000);
    send_request(ACT_CLEAR, 32'd0, 3'd0, 32'd0);
    wait_idle();

    run_phase(32'd0, 32'd65536, 270);
    run_phase(32'hFFFF_FF00, 32'hFFFF_FFFF, 270);
    run_phase($urandom | 32'd1, 32'd0, 80);
    run_phase($urandom, 32'd300, 230);
    run_phase(32'hFFFF_FFFF, $urandom_range(1, 65535), 250);

    if (sb.pending() != 0) sb.report("expected results never arrived");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
